// ===== sv/touch_report_frame_assembler_core_defines.svh =====
// Assertion macros for the touch report frame assembler.
// No dependencies.
`ifndef TOUCH_REPORT_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define TOUCH_REPORT_FRAME_ASSEMBLER_CORE_DEFINES_SVH
`define TRFA_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lbl");
`define TRFA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lbl");
`endif

// ===== sv/trfa_pkg.sv =====
// Package for the touch report frame assembler: constants, types, helpers.
// No dependencies.
package trfa_pkg;
	localparam int MaxContacts = 16;
	localparam logic [31:0] TimeoutReset = 32'd100;
	localparam logic [16:0] PosOne = 17'd65536;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	function automatic logic [16:0] clamp_pos(input logic signed [17:0] v);
		logic [16:0] r;
		if (v < 0) r = '0;
		else if (v > $signed({1'b0, PosOne})) r = PosOne;
		else r = v[16:0];
		return r;
	endfunction
endpackage

// ===== sv/trfa_store.sv =====
// Contact store of the frame assembler: id, x and y per entry.
// Depends on trfa_pkg.
module trfa_store #(
	parameter int MAX_CONTACTS = trfa_pkg::MaxContacts,
	localparam int AW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [41:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [41:0]   rdata
);
	logic [41:0] mem [MAX_CONTACTS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== sv/touch_report_frame_assembler_core.sv =====
// Top level of the touch report frame assembler: header control and sequencer.
// Depends on trfa_pkg, trfa_store and the defines header.
//
// channel | dir | handshake        | payload
// in      | in  | in_valid/ready   | report header and one slot
// out     | out | out_valid/ready  | one contact of a frame or empty frame
// cfg     | in  | cfg_we           | timeout_ticks
//
// A slot that adds to a frame is followed by an id search: the stored entries are read in
// order through the single store read port into one shared compare, until a hit or the end
// of the store; the input is not ready during the search.
// Emission of a frame or an empty frame also holds the input; other slots do not hold it.
// Reset clears control state; store contents are undefined until written.
// Output stalls hold the sequencer in place while it emits.
`include "touch_report_frame_assembler_core_defines.svh"
module touch_report_frame_assembler_core #(
	parameter int MAX_CONTACTS = trfa_pkg::MaxContacts,
	localparam int AW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1,
	localparam int CW = $clog2(MAX_CONTACTS + 1),
	localparam int EW = (CW > 5) ? CW : 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first_of_report,
	input  logic               last_of_report,
	input  logic signed [5:0]  report_count,
	input  logic [15:0]        scan_time,
	input  logic [31:0]        report_time,
	input  logic               slot_present,
	input  logic               slot_fields_valid,
	input  logic               slot_tip,
	input  logic [7:0]         contact_id,
	input  logic signed [17:0] x_pos,
	input  logic signed [17:0] y_pos,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_contact_id,
	output logic [16:0]        out_x,
	output logic [16:0]        out_y,
	output logic               empty_frame,
	output logic               last_of_frame,
	output logic [4:0]         frame_count
);
	trfa_pkg::state_t state_q, state_d;

	logic [31:0]   timeout_q;
	logic          pending_q;
	logic [4:0]    expected_q;
	logic [15:0]   fscan_q;
	logic [31:0]   last_add_q;
	logic [CW-1:0] stored_q;
	logic          prev_q;
	logic          adds_q;

	logic [7:0]    id_q;
	logic [16:0]   x_q, y_q;
	logic          usable_q;
	logic          last_q;
	logic [CW-1:0] idx_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [41:0]   wdata, rdata;
	logic          rd_ok_q;

	// output register
	logic          ov_q;
	logic [7:0]    oid_q;
	logic [16:0]   ox_q, oy_q;
	logic          oempty_q, olast_q;
	logic [4:0]    ocnt_q;

	assign in_ready       = (state_q == trfa_pkg::ST_IDLE);
	assign out_valid      = ov_q;
	assign out_contact_id = oid_q;
	assign out_x          = ox_q;
	assign out_y          = oy_q;
	assign empty_frame    = oempty_q;
	assign last_of_frame  = olast_q;
	assign frame_count    = ocnt_q;

	logic in_fire;
	assign in_fire = in_valid && in_ready;
	logic out_free;
	assign out_free = !ov_q || out_ready;

	// header evaluation
	logic        complete;
	logic        timed_out, same, do_resolve, resolve_emits;
	logic        h_adds, h_start, h_cont, h_empty, h_drop;
	always_comb begin
		complete   = (expected_q != '0) && (EW'(stored_q) == EW'(expected_q));
		timed_out  = pending_q && ((report_time - last_add_q) > timeout_q);
		same       = (fscan_q == scan_time) || (fscan_q == '0) || (scan_time == '0);
		do_resolve = pending_q && (timed_out || (report_count > 0) || !same);
		resolve_emits = do_resolve && complete;
		h_start = !resolve_emits && (report_count > 0);
		h_cont  = !do_resolve && pending_q && same && !(report_count > 0);
		h_drop  = do_resolve && !complete;
		h_empty = !resolve_emits && !h_start && !h_cont && (report_count == 0)
			&& prev_q;
		h_adds  = h_start || h_cont;
	end

	logic eff_adds;
	assign eff_adds = first_of_report ? h_adds : adds_q;

	// search compare
	logic hit;
	assign hit = rd_ok_q && (rdata[41:34] == id_q);

	// search end conditions computed for the completion check
	logic          search_end, appended;
	logic [CW-1:0] stored_after;
	logic          complete_after;
	always_comb begin
		search_end = (state_q == trfa_pkg::ST_SEARCH)
			&& (hit || (idx_q >= stored_q && !rd_ok_q) || !usable_q);
		appended = search_end && usable_q && !hit && (stored_q < CW'(MAX_CONTACTS));
		stored_after = appended ? stored_q + CW'(1) : stored_q;
		complete_after = (expected_q != '0) && (EW'(stored_after) == EW'(expected_q));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trfa_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (first_of_report && resolve_emits) state_d = trfa_pkg::ST_EMIT;
					else if (first_of_report && h_empty) state_d = trfa_pkg::ST_EMPTY;
					else if (eff_adds) state_d = trfa_pkg::ST_SEARCH;
				end
			end
			trfa_pkg::ST_SEARCH: begin
				if (search_end) begin
					if (last_q && pending_q && complete_after) state_d = trfa_pkg::ST_EMIT;
					else state_d = trfa_pkg::ST_IDLE;
				end
			end
			trfa_pkg::ST_EMIT: begin
				if (out_free && idx_q == stored_q && !rd_ok_q) state_d = trfa_pkg::ST_IDLE;
			end
			trfa_pkg::ST_EMPTY: begin
				if (out_free) state_d = trfa_pkg::ST_IDLE;
			end
			default: state_d = trfa_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = stored_q[AW-1:0];
		wdata = {id_q, x_q, y_q};
		if (search_end && usable_q) begin
			if (hit) begin
				we    = 1'b1;
				waddr = AW'(idx_q - CW'(1));
			end else if (stored_q < CW'(MAX_CONTACTS)) begin
				we = 1'b1;
			end
		end
	end

	logic rd_issue;
	always_comb begin
		rd_issue = 1'b0;
		if (state_q == trfa_pkg::ST_SEARCH && !search_end && idx_q < stored_q) rd_issue = 1'b1;
		if (state_q == trfa_pkg::ST_EMIT && idx_q < stored_q && (!rd_ok_q || out_free))
			rd_issue = 1'b1;
	end
	assign raddr = idx_q[AW-1:0];

	logic beat_emit, beat_empty, hdr_fire, emit_done;
	always_comb begin
		beat_emit  = (state_q == trfa_pkg::ST_EMIT) && rd_ok_q && out_free;
		beat_empty = (state_q == trfa_pkg::ST_EMPTY) && out_free;
		hdr_fire   = in_fire && first_of_report;
		emit_done  = (state_q == trfa_pkg::ST_EMIT) && (state_d == trfa_pkg::ST_IDLE);
	end

	trfa_store #(.MAX_CONTACTS(MAX_CONTACTS)) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_issue),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= trfa_pkg::ST_IDLE;
			timeout_q  <= trfa_pkg::TimeoutReset;
			pending_q  <= 1'b0;
			expected_q <= '0;
			fscan_q    <= '0;
			last_add_q <= '0;
			stored_q   <= '0;
			prev_q     <= 1'b0;
			adds_q     <= 1'b0;
			idx_q      <= '0;
			rd_ok_q    <= 1'b0;
			ov_q       <= 1'b0;
			last_q     <= 1'b0;
			usable_q   <= 1'b0;
			oempty_q   <= 1'b0;
			olast_q    <= 1'b0;
			ocnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (beat_emit || beat_empty) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			rd_ok_q <= rd_issue || ((state_q == trfa_pkg::ST_EMIT) && rd_ok_q && !out_free);
			if (rd_issue) idx_q <= idx_q + CW'(1);
			else if ((state_q == trfa_pkg::ST_IDLE) || search_end) idx_q <= '0;
			if (in_fire) begin
				usable_q <= slot_present && slot_fields_valid && slot_tip;
				last_q   <= last_of_report;
				adds_q   <= last_of_report ? 1'b0 : eff_adds;
			end else if (emit_done) begin
				adds_q <= 1'b0;
			end
			if (hdr_fire && h_start) begin
				pending_q  <= 1'b1;
				expected_q <= report_count[4:0];
				fscan_q    <= scan_time;
			end else if (hdr_fire && h_drop) begin
				pending_q  <= 1'b0;
				expected_q <= '0;
				fscan_q    <= '0;
			end else if (emit_done) begin
				pending_q  <= 1'b0;
			end
			if (hdr_fire && (h_start || h_cont)) last_add_q <= report_time;
			else if ((hdr_fire && h_drop) || emit_done) last_add_q <= '0;
			if (hdr_fire && (h_start || h_drop)) stored_q <= '0;
			else if (search_end) stored_q <= stored_after;
			else if (emit_done) stored_q <= '0;
			if (hdr_fire && h_empty) prev_q <= 1'b0;
			else if (emit_done) prev_q <= 1'b1;
			if (beat_emit) begin
				oempty_q <= 1'b0;
				olast_q  <= (idx_q == stored_q) && !rd_issue;
				ocnt_q   <= 5'(stored_q);
			end else if (beat_empty) begin
				oempty_q <= 1'b1;
				olast_q  <= 1'b1;
				ocnt_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_q <= contact_id;
			x_q  <= trfa_pkg::clamp_pos(x_pos);
			y_q  <= trfa_pkg::clamp_pos(y_pos);
		end
		if (beat_emit) begin
			oid_q <= rdata[41:34];
			ox_q  <= rdata[33:17];
			oy_q  <= rdata[16:0];
		end else if (beat_empty) begin
			oid_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
		end
	end

	`TRFA_ASSERT_IMPL(a_busy_not_ready, state_q != trfa_pkg::ST_IDLE, !in_ready)
	`TRFA_ASSERT_IMPL(a_store_bound, 1'b1, stored_q <= CW'(MAX_CONTACTS))
	`TRFA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_contact_id))
endmodule

// ===== tb/sv/tb.sv =====
// Testbench for touch_report_frame_assembler_core: directed and random report streams with a
// built-in frame assembly predictor, checked beat by beat at the result port.
// Depends on trfa_pkg and the core RTL.
module tb;
	typedef struct {
		logic               first, last;
		logic signed [5:0]  cnt;
		logic [15:0]        scan;
		logic [31:0]        tm;
		logic               pres, fv, tip;
		logic [7:0]         id;
		logic signed [17:0] x, y;
	} slot_item_t;

	typedef struct {
		logic [7:0]  id;
		logic [16:0] x, y;
		logic        empty, last;
		logic [4:0]  cnt;
	} contact_beat_t;

	logic clk = 0, arst_n = 0;
	logic cfg_we = 0;
	logic [31:0] cfg_wdata = '0;
	logic in_valid = 0, in_ready;
	logic first_of_report = 0, last_of_report = 0;
	logic signed [5:0] report_count = '0;
	logic [15:0] scan_time = '0;
	logic [31:0] report_time = '0;
	logic slot_present = 0, slot_fields_valid = 0, slot_tip = 0;
	logic [7:0] contact_id = '0;
	logic signed [17:0] x_pos = '0, y_pos = '0;
	logic out_valid, out_ready = 0;
	logic [7:0] out_contact_id;
	logic [16:0] out_x, out_y;
	logic empty_frame, last_of_frame;
	logic [4:0] frame_count;

	touch_report_frame_assembler_core DUT (.*);

	always #5 clk = ~clk;

	slot_item_t pending_slots[$];
	contact_beat_t frame_beats[$];
	slot_item_t cur;
	logic in_taken = 0;
	int send_idle = 0, recv_stall = 0, errors = 0;
	logic [31:0] now_ticks = 0;

	// predictor state
	logic [31:0] timeout_ticks = trfa_pkg::TimeoutReset;
	logic        pend = 0, prev_touch = 0, adds = 0;
	logic [4:0]  want_cnt = 0;
	logic [15:0] frame_scan = 0;
	logic [31:0] last_add = 0;
	logic [7:0]  st_id[16];
	logic [16:0] st_x[16], st_y[16];
	int          n_stored = 0;

	function automatic logic [16:0] limit_pos(logic signed [17:0] v);
		if (v < 0) return '0;
		if (v > 18'sd65536) return trfa_pkg::PosOne;
		return v[16:0];
	endfunction

	function automatic int emit_frame();
		contact_beat_t b;
		int n;
		n = n_stored;
		for (int k = 0; k < n; k++) begin
			b.id = st_id[k]; b.x = st_x[k]; b.y = st_y[k];
			b.empty = 1'b0; b.last = (k == n - 1); b.cnt = 5'(n);
			frame_beats.insert(frame_beats.size(), b);
		end
		pend = 0; last_add = 0; prev_touch = 1; n_stored = 0;
		return n;
	endfunction

	function automatic int resolve_frame();
		if (!pend) return 0;
		pend = 0;
		if (want_cnt != 0 && n_stored == want_cnt) return emit_frame();
		want_cnt = 0; frame_scan = 0; last_add = 0; n_stored = 0;
		return 0;
	endfunction

	function automatic void store_contact(slot_item_t s);
		logic [16:0] px, py;
		if (!(s.pres && s.fv && s.tip)) return;
		px = limit_pos(s.x);
		py = limit_pos(s.y);
		for (int i = 0; i < n_stored; i++)
			if (st_id[i] == s.id) begin
				st_x[i] = px; st_y[i] = py;
				return;
			end
		if (n_stored < trfa_pkg::MaxContacts) begin
			st_id[n_stored] = s.id; st_x[n_stored] = px; st_y[n_stored] = py;
			n_stored++;
		end
	endfunction

	function automatic void assemble(slot_item_t s);
		int n;
		contact_beat_t b;
		n = 0;
		if (s.first) begin
			adds = 0;
			if (pend && (s.tm - last_add) > timeout_ticks) n = resolve_frame();
			if (n == 0) begin
				if (s.cnt > 0) begin
					if (pend) n = resolve_frame();
					if (n == 0) begin
						pend = 1; want_cnt = s.cnt[4:0]; frame_scan = s.scan;
						n_stored = 0; last_add = s.tm; adds = 1;
					end
				end else if (pend && (frame_scan == s.scan || frame_scan == 0
						|| s.scan == 0)) begin
					last_add = s.tm; adds = 1;
				end else begin
					if (pend) n = resolve_frame();
					if (n == 0 && s.cnt == 0 && prev_touch) begin
						b.id = '0; b.x = '0; b.y = '0;
						b.empty = 1'b1; b.last = 1'b1; b.cnt = '0;
						frame_beats.insert(frame_beats.size(), b);
						prev_touch = 0;
					end
				end
			end
		end
		if (adds) store_contact(s);
		if (s.last) begin
			if (adds && pend && want_cnt != 0 && n_stored == want_cnt) n = emit_frame();
			adds = 0;
		end
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_slots.size() != 0 && $urandom_range(99) >= send_idle) begin
				cur = pending_slots.pop_front();
				first_of_report <= cur.first; last_of_report <= cur.last;
				report_count <= cur.cnt; scan_time <= cur.scan; report_time <= cur.tm;
				slot_present <= cur.pres; slot_fields_valid <= cur.fv; slot_tip <= cur.tip;
				contact_id <= cur.id; x_pos <= cur.x; y_pos <= cur.y;
				in_valid <= 1;
			end else
				in_valid <= 0;
		end
		in_taken <= 0;
		out_ready <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	// monitor
	always @(posedge clk) begin
		contact_beat_t e;
		if (arst_n && in_valid && in_ready) begin
			assemble(cur);
			in_taken <= 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (frame_beats.size() == 0) begin
				$error("unexpected beat id=%0d", out_contact_id);
				errors++;
			end else begin
				e = frame_beats.pop_front();
				if (out_contact_id !== e.id) begin
					$error("out_contact_id exp %0d got %0d", e.id, out_contact_id); errors++;
				end
				if (out_x !== e.x) begin
					$error("out_x exp %0d got %0d", e.x, out_x); errors++;
				end
				if (out_y !== e.y) begin
					$error("out_y exp %0d got %0d", e.y, out_y); errors++;
				end
				if (empty_frame !== e.empty) begin
					$error("empty_frame exp %0d got %0d", e.empty, empty_frame); errors++;
				end
				if (last_of_frame !== e.last) begin
					$error("last_of_frame exp %0d got %0d", e.last, last_of_frame); errors++;
				end
				if (frame_count !== e.cnt) begin
					$error("frame_count exp %0d got %0d", e.cnt, frame_count); errors++;
				end
			end
		end
	end

	task automatic add_slot(logic first, logic last, logic signed [5:0] cnt,
			logic [15:0] scan, logic pres, logic fv, logic tip, logic [7:0] id,
			logic signed [17:0] x, logic signed [17:0] y);
		slot_item_t s;
		s.first = first; s.last = last; s.cnt = cnt; s.scan = scan; s.tm = now_ticks;
		s.pres = pres; s.fv = fv; s.tip = tip; s.id = id; s.x = x; s.y = y;
		pending_slots.insert(pending_slots.size(), s);
	endtask

	function automatic logic signed [17:0] rand_pos();
		case ($urandom_range(3))
			0: return 18'($urandom);
			1: return $urandom_range(4) == 0 ? 18'sd65536 : -18'sd1;
			default: return 18'($urandom_range(65536));
		endcase
	endfunction

	// one report: header count, a few slots with ids from a small pool
	task automatic add_report(logic signed [5:0] cnt, int nslots, logic [15:0] scan,
			bit clean);
		logic [7:0] id;
		for (int i = 0; i < nslots; i++) begin
			id = clean ? 8'(i) : 8'($urandom_range(7));
			add_slot(i == 0, i == nslots - 1 && (clean || $urandom_range(19) != 0),
				cnt, scan, clean || $urandom_range(9) != 0,
				clean || $urandom_range(9) != 0, clean || $urandom_range(9) != 0,
				$urandom_range(9) == 0 ? 8'hFF - id : id, rand_pos(), rand_pos());
		end
		now_ticks += $urandom_range(9) == 0 ? $urandom : $urandom_range(40);
	endtask

	task automatic random_phase(int reports);
		slot_item_t s;
		logic [15:0] scan;
		int k;
		scan = 16'($urandom_range(3));
		for (int r = 0; r < reports; r++) begin
			k = $urandom_range(1, 4);
			case ($urandom_range(9))
				0, 1, 2: add_report(6'(k), k, scan, 1'b1);
				3: add_report(6'sd0, $urandom_range(1, 2), scan, 1'b0);
				4: add_report(-6'sd1, $urandom_range(1, 3), 16'($urandom_range(3)), 1'b0);
				5: add_report(6'(k), $urandom_range(1, 6), 16'($urandom_range(3)), 1'b0);
				6: add_report(6'($urandom), $urandom_range(1, 3), 16'($urandom), 1'b0);
				7: begin
					s.first = 1'($urandom); s.last = 1'($urandom); s.cnt = 6'($urandom);
					s.scan = 16'($urandom); s.tm = $urandom; s.pres = 1'($urandom);
					s.fv = 1'($urandom); s.tip = 1'($urandom); s.id = 8'($urandom);
					s.x = 18'($urandom); s.y = 18'($urandom);
					pending_slots.insert(pending_slots.size(), s);
				end
				default: begin
					add_report(6'(k), 1, scan, 1'b0);
					add_report(6'sd0, k, scan, 1'b0);
				end
			endcase
		end
	endtask

	task automatic drain_and_config(logic [31:0] val);
		while (pending_slots.size() != 0 || in_valid || frame_beats.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1; cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
		timeout_ticks = val;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: full frame of 16, odd counts, coordinate extremes
		add_report(6'sd16, 16, 16'hFFFF, 1'b1);
		add_report(6'sd0, 1, 16'hFFFF, 1'b0);
		add_report(6'sd0, 1, 16'd0, 1'b1);
		add_slot(1'b1, 1'b0, 6'sd2, 16'd5, 1'b1, 1'b1, 1'b1, 8'd0, 18'sh20000, 18'sd131071);
		add_slot(1'b0, 1'b0, 6'sd2, 16'd5, 1'b1, 1'b1, 1'b1, 8'd0, 18'sd65537, 18'sd65536);
		add_slot(1'b0, 1'b0, 6'sd2, 16'd5, 1'b0, 1'b1, 1'b1, 8'd9, 18'sd0, 18'sd0);
		add_slot(1'b0, 1'b0, 6'sd2, 16'd5, 1'b1, 1'b0, 1'b1, 8'd9, 18'sd0, 18'sd0);
		add_slot(1'b0, 1'b0, 6'sd2, 16'd5, 1'b1, 1'b1, 1'b0, 8'd9, 18'sd0, 18'sd0);
		add_slot(1'b0, 1'b1, 6'sd2, 16'd5, 1'b1, 1'b1, 1'b1, 8'd255, 18'sd1, 18'sd65535);
		add_report(6'sd31, 3, 16'd7, 1'b0);
		add_report(6'sh20, 2, 16'd8, 1'b0);
		add_report(6'sd0, 1, 16'd0, 1'b0);
		add_report(6'sd3, 2, 16'd9, 1'b1);
		add_report(-6'sd1, 1, 16'd9, 1'b1);
		now_ticks = 32'hFFFF_FFF0;
		add_report(6'sd2, 1, 16'd4, 1'b1);
		drain_and_config(32'd0);
		add_report(6'sd2, 1, 16'd4, 1'b1);
		add_report(6'sd0, 2, 16'd4, 1'b1);
		random_phase(30);

		drain_and_config(32'hFFFF_FFFF);
		random_phase(40);
		drain_and_config(32'd30);
		send_idle = 78;
		random_phase(40);
		drain_and_config(32'd0);
		send_idle = 0; recv_stall = 78;
		random_phase(40);
		drain_and_config(32'd100);
		send_idle = 11; recv_stall = 11;
		random_phase(40);

		while (pending_slots.size() != 0 || in_valid || frame_beats.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && frame_beats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
